// File: hw/rtl/stnsg_pkg.sv
// Package: constants and types shared by the sound generator files.
`default_nettype none
package stnsg_pkg;

	localparam int TONE_CHANNELS = 3;
	localparam int MAX_VOLUME    = 15;
	localparam int SAMPLE_RATE   = 48000;

	localparam int REQ_TYPE_W = 2;
	localparam int CHANNEL_W  = 2;
	localparam int VALUE_W    = 16;
	localparam int MIX_W      = 7;

	localparam int PHASE_W   = 32;
	localparam int LFSR_W    = 16;
	localparam int VOL_BYTE_W = 8;
	localparam int LEVEL_W   = $clog2(MAX_VOLUME + 1);

	localparam logic [LFSR_W-1:0] LFSR_TAPS  = 16'hB800;
	localparam logic [LFSR_W-1:0] LFSR_SEED  = 16'h0001;
	localparam int                NOISE_RESET_BIT = 7;

	// Step = floor(freq * 2^PHASE_W / SAMPLE_RATE) through a scaled reciprocal.
	// 2^RATE_W exceeds SAMPLE_RATE, so the rounding error never moves the floor.
	localparam int RATE_W      = 18;
	localparam int SHIFT_S     = VALUE_W + RATE_W;
	localparam int RECIP_EXP   = PHASE_W + SHIFT_S;
	localparam int RECIP_W     = RECIP_EXP + 1 - $clog2(SAMPLE_RATE);
	localparam int RECIP_LO_W  = RECIP_W / 2;
	localparam int RECIP_HI_W  = RECIP_W - RECIP_LO_W;
	localparam int NUM_W       = RECIP_EXP + 4;
	localparam logic [NUM_W-1:0] RECIP_FULL =
		((NUM_W'(1) << RECIP_EXP) + NUM_W'(SAMPLE_RATE - 1)) / NUM_W'(SAMPLE_RATE);
	localparam logic [RECIP_HI_W-1:0] RECIP_HI = RECIP_FULL[RECIP_W-1:RECIP_LO_W];
	localparam logic [RECIP_LO_W-1:0] RECIP_LO = RECIP_FULL[RECIP_LO_W-1:0];
	localparam int PROD_HI_W   = VALUE_W + RECIP_HI_W;
	localparam int PROD_LO_W   = VALUE_W + RECIP_LO_W;
	localparam int PROD_W      = VALUE_W + RECIP_W + 1;

	localparam int SUM_RAW_W = $clog2(MAX_VOLUME * (TONE_CHANNELS + 1) + 1) + 1;
	localparam int SUM_W     = (SUM_RAW_W > MIX_W + 1) ? SUM_RAW_W : MIX_W + 1;
	localparam int MIX_MAX   = 2 ** (MIX_W - 1) - 1;
	localparam int MIX_MIN   = -(2 ** (MIX_W - 1));

	typedef enum logic [REQ_TYPE_W-1:0] {
		REQ_TICK   = 2'd0,
		REQ_VOLUME = 2'd1,
		REQ_FREQ   = 2'd2
	} req_type_t;

endpackage
`default_nettype wire

// File: hw/rtl/stnsg_req_if.sv
// Interface: request channel carrying ticks, volume writes and frequency writes.
`default_nettype none
interface stnsg_req_if;
	import stnsg_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [REQ_TYPE_W-1:0] req_type;
	logic [CHANNEL_W-1:0]  channel;
	logic [VALUE_W-1:0]    value;

	modport source (output valid, output req_type, output channel, output value,
		input ready);
	modport sink (input valid, input req_type, input channel, input value,
		output ready);
endinterface
`default_nettype wire

// File: hw/rtl/stnsg_mix_if.sv
// Interface: result channel carrying the signed channel mix.
`default_nettype none
interface stnsg_mix_if;
	import stnsg_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [MIX_W-1:0] mix_sum;

	modport source (output valid, output mix_sum, input ready);
	modport sink (input valid, input mix_sum, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/stnsg_step_calc.sv
// Phase step from frequency: split reciprocal multiply, registered, then summed.
`default_nettype none
module stnsg_step_calc (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [stnsg_pkg::VALUE_W-1:0] freq,
	output logic      [stnsg_pkg::PHASE_W-1:0] step
);
	import stnsg_pkg::*;

	logic [PROD_HI_W-1:0] prod_hi_s2;
	logic [PROD_LO_W-1:0] prod_lo_s2;
	logic [PROD_W-1:0]    full;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_hi_s2 <= PROD_HI_W'(freq) * PROD_HI_W'(RECIP_HI);
			prod_lo_s2 <= PROD_LO_W'(freq) * PROD_LO_W'(RECIP_LO);
		end
	end

	assign full = (PROD_W'(prod_hi_s2) << RECIP_LO_W) + PROD_W'(prod_lo_s2);
	assign step = full[SHIFT_S +: PHASE_W];
endmodule
`default_nettype wire

// File: hw/rtl/square_tone_noise_sound_generator.sv
// Top level: square-wave tone channels plus one LFSR noise channel, mixed per tick.
//
// Usage:
//   req channel (valid/ready): req_type selects a sample tick, a volume write or a
//   frequency write; channel picks a tone channel or, at TONE_CHANNELS, the noise
//   channel; value is the volume byte or the frequency in hertz.
//   mix channel (valid/ready): one signed mix_sum per sample tick; writes and
//   unused request types produce no transfer.
//   A tick accepted into the input register moves to stage 2, then its mix_sum is
//   registered in the result register. Throughput is one request per cycle
//   unless stalled; the three-stage path is input register, registered reciprocal
//   multiply for the frequency step, then channel update and result register.
//   Requests take effect strictly in order: a write reaches the channel state in
//   the same stage where ticks read it.
//   Reset: all phases, steps and levels clear, the noise LFSR loads 1, and all
//   stages and the result register empty.
//   Stall: while mix.ready is low the result holds; the two stages behind it keep
//   filling, and req.ready drops only once both hold a request.
`default_nettype none
module square_tone_noise_sound_generator (
	input wire logic  clk,
	input wire logic  arst_n,
	stnsg_req_if.sink req,
	stnsg_mix_if.source mix
);
	import stnsg_pkg::*;

	localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(MIX_MAX);
	localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(MIX_MIN);

	// stage 1
	logic                  valid_s1;
	req_type_t             type_s1;
	logic [CHANNEL_W-1:0]  ch_s1;
	logic [VALUE_W-1:0]    value_s1;
	// stage 2
	logic                  valid_s2;
	req_type_t             type_s2;
	logic [CHANNEL_W-1:0]  ch_s2;
	logic [VOL_BYTE_W-1:0] vol_s2;
	logic [PHASE_W-1:0]    step_s2;

	logic s1_move, s1_ready, s2_move, s2_ready, s2_tick, out_free;

	// channel state
	logic [PHASE_W-1:0] tone_phase_q [TONE_CHANNELS];
	logic [PHASE_W-1:0] tone_step_q  [TONE_CHANNELS];
	logic [LEVEL_W-1:0] tone_level_q [TONE_CHANNELS];
	logic [PHASE_W-1:0] noise_phase_q;
	logic [PHASE_W-1:0] noise_step_q;
	logic [LEVEL_W-1:0] noise_level_q;
	logic [LFSR_W-1:0]  noise_shift_q;

	// result register
	logic                    out_v_q;
	logic signed [MIX_W-1:0] mix_q;

	// combinational channel logic
	logic [PHASE_W-1:0]      tone_phase_nx [TONE_CHANNELS];
	logic [TONE_CHANNELS-1:0] tone_active;
	logic                    noise_active;
	logic [PHASE_W:0]        noise_sum;
	logic [LFSR_W-1:0]       noise_shift_nx;
	logic signed [SUM_W-1:0] sum;
	logic signed [MIX_W-1:0] mix_nx;
	logic [LEVEL_W-1:0]      vol_level;
	logic                    noise_sel;

	assign out_free = !out_v_q || mix.ready;
	assign s2_tick  = valid_s2 && (type_s2 == REQ_TICK);
	assign s2_move  = valid_s2 && (!s2_tick || out_free);
	assign s2_ready = !valid_s2 || s2_move;
	assign s1_move  = valid_s1 && s2_ready;
	assign s1_ready = !valid_s1 || s1_move;
	assign req.ready = s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_ready)
				valid_s1 <= req.valid;
			if (s2_ready)
				valid_s2 <= s1_move;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && s1_ready) begin
			type_s1  <= req_type_t'(req.req_type);
			ch_s1    <= req.channel;
			value_s1 <= req.value;
		end
		if (s1_move) begin
			type_s2 <= type_s1;
			ch_s2   <= ch_s1;
			vol_s2  <= value_s1[VOL_BYTE_W-1:0];
		end
	end

	stnsg_step_calc u_step (
		.clk  (clk),
		.en   (s1_move),
		.freq (value_s1),
		.step (step_s2)
	);

	always_comb begin
		sum = '0;
		for (int i = 0; i < TONE_CHANNELS; i++) begin
			tone_active[i]   = (tone_level_q[i] != '0) && (tone_step_q[i] != '0);
			tone_phase_nx[i] = tone_phase_q[i] + tone_step_q[i];
			if (tone_active[i]) begin
				if (tone_phase_nx[i][PHASE_W-1])
					sum = sum + SUM_W'(tone_level_q[i]);
				else
					sum = sum - SUM_W'(tone_level_q[i]);
			end
		end
		noise_active = (noise_level_q != '0) && (noise_step_q != '0);
		noise_sum    = {1'b0, noise_phase_q} + {1'b0, noise_step_q};
		if (noise_sum[PHASE_W])
			noise_shift_nx = {1'b0, noise_shift_q[LFSR_W-1:1]} ^
				(noise_shift_q[0] ? LFSR_TAPS : '0);
		else
			noise_shift_nx = noise_shift_q;
		if (noise_active) begin
			if (noise_shift_nx[0])
				sum = sum + SUM_W'(noise_level_q);
			else
				sum = sum - SUM_W'(noise_level_q);
		end
		if (sum > SUM_MAX)
			mix_nx = SUM_MAX[MIX_W-1:0];
		else if (sum < SUM_MIN)
			mix_nx = SUM_MIN[MIX_W-1:0];
		else
			mix_nx = sum[MIX_W-1:0];
	end

	assign vol_level = (vol_s2 > VOL_BYTE_W'(MAX_VOLUME)) ? LEVEL_W'(MAX_VOLUME) :
		vol_s2[LEVEL_W-1:0];
	assign noise_sel = (int'(ch_s2) == TONE_CHANNELS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TONE_CHANNELS; i++) begin
				tone_phase_q[i] <= '0;
				tone_step_q[i]  <= '0;
				tone_level_q[i] <= '0;
			end
			noise_phase_q <= '0;
			noise_step_q  <= '0;
			noise_level_q <= '0;
			noise_shift_q <= LFSR_SEED;
		end else if (s2_move) begin
			unique case (type_s2)
				REQ_TICK: begin
					for (int i = 0; i < TONE_CHANNELS; i++) begin
						if (tone_active[i])
							tone_phase_q[i] <= tone_phase_nx[i];
					end
					if (noise_active) begin
						noise_phase_q <= noise_sum[PHASE_W-1:0];
						noise_shift_q <= noise_shift_nx;
					end
				end
				REQ_VOLUME: begin
					for (int i = 0; i < TONE_CHANNELS; i++) begin
						if (int'(ch_s2) == i)
							tone_level_q[i] <= vol_level;
					end
					if (noise_sel) begin
						noise_level_q <= vol_level;
						if (vol_s2[NOISE_RESET_BIT]) begin
							noise_phase_q <= '0;
							noise_shift_q <= LFSR_SEED;
						end
					end
				end
				REQ_FREQ: begin
					for (int i = 0; i < TONE_CHANNELS; i++) begin
						if (int'(ch_s2) == i)
							tone_step_q[i] <= step_s2;
					end
					if (noise_sel)
						noise_step_q <= step_s2;
				end
				default: begin
					// drop unused request codes
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (s2_move && s2_tick)
			out_v_q <= 1'b1;
		else if (mix.ready)
			out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s2_move && s2_tick)
			mix_q <= mix_nx;
	end

	assign mix.valid   = out_v_q;
	assign mix.mix_sum = mix_q;

	a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		noise_shift_q != '0)
		else $error("noise LFSR reached the all-zero state");

	a_level_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		noise_level_q <= LEVEL_W'(MAX_VOLUME))
		else $error("noise level above maximum volume");

	a_result_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !$past(out_v_q)) |-> $past(s2_move && s2_tick))
		else $error("result appeared without a tick leaving stage 2");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (valid_s1 && valid_s2 && out_v_q && !mix.ready))
		else $error("request side stalled with room in the pipeline");
endmodule
`default_nettype wire

// File: sim/tb_square_tone_noise_sound_generator.sv
// Testbench for the square-tone and noise sound generator: directed and random traffic, scored mix.
`timescale 1ns / 100ps
`default_nettype none
module tb_square_tone_noise_sound_generator;
	import stnsg_pkg::*;

	localparam logic [REQ_TYPE_W-1:0] REQ_RESERVED = 2'd3;
	localparam logic [CHANNEL_W-1:0]  NOISE_CH     = CHANNEL_W'(TONE_CHANNELS);
	localparam int IDLE_LIMIT   = 2000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;

	logic clk;
	logic arst_n;

	stnsg_req_if req_if ();
	stnsg_mix_if mix_if ();

	square_tone_noise_sound_generator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.mix    (mix_if)
	);

	logic [PHASE_W-1:0]  tone_acc [TONE_CHANNELS];
	logic [PHASE_W-1:0]  tone_inc [TONE_CHANNELS];
	logic [LEVEL_W-1:0]  tone_vol [TONE_CHANNELS];
	logic [PHASE_W-1:0]  noise_acc;
	logic [PHASE_W-1:0]  noise_inc;
	logic [LEVEL_W-1:0]  noise_vol;
	logic [LFSR_W-1:0]   noise_lfsr;

	logic signed [MIX_W-1:0] pending_mix [$];

	int  errors;
	int  burst_left;
	bit  no_gaps;
	bit  hold_off_req;
	int  idle_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [PHASE_W-1:0] phase_step_for(logic [VALUE_W-1:0] freq);
		logic [63:0] num;
		num = {16'd0, freq, 32'd0};
		return PHASE_W'(num / 64'(SAMPLE_RATE));
	endfunction

	function automatic logic [LEVEL_W-1:0] level_for(logic [VALUE_W-1:0] val);
		logic [VOL_BYTE_W-1:0] vbyte;
		vbyte = val[VOL_BYTE_W-1:0];
		return (vbyte > MAX_VOLUME) ? LEVEL_W'(MAX_VOLUME) : LEVEL_W'(vbyte);
	endfunction

	task automatic clear_mixer_state();
		for (int i = 0; i < TONE_CHANNELS; i++) begin
			tone_acc[i] = '0;
			tone_inc[i] = '0;
			tone_vol[i] = '0;
		end
		noise_acc  = '0;
		noise_inc  = '0;
		noise_vol  = '0;
		noise_lfsr = LFSR_SEED;
	endtask

	task automatic advance_mixer(input logic [REQ_TYPE_W-1:0] rt,
			input logic [CHANNEL_W-1:0] ch, input logic [VALUE_W-1:0] val);
		int total;
		logic [PHASE_W:0] wide;
		logic shifted;
		total = 0;
		if (rt == REQ_VOLUME || rt == REQ_FREQ) begin
			if (ch < NOISE_CH) begin
				if (rt == REQ_VOLUME)
					tone_vol[ch] = level_for(val);
				else
					tone_inc[ch] = phase_step_for(val);
			end else if (ch == NOISE_CH) begin
				if (rt == REQ_VOLUME) begin
					noise_vol = level_for(val);
					if (val[NOISE_RESET_BIT]) begin
						noise_acc  = '0;
						noise_lfsr = LFSR_SEED;
					end
				end else begin
					noise_inc = phase_step_for(val);
				end
			end
		end else if (rt == REQ_TICK) begin
			for (int i = 0; i < TONE_CHANNELS; i++) begin
				if (tone_vol[i] != 0 && tone_inc[i] != 0) begin
					tone_acc[i] = tone_acc[i] + tone_inc[i];
					total += tone_acc[i][PHASE_W-1] ? int'(tone_vol[i]) : -int'(tone_vol[i]);
				end
			end
			if (noise_vol != 0 && noise_inc != 0) begin
				wide = {1'b0, noise_acc} + {1'b0, noise_inc};
				noise_acc = wide[PHASE_W-1:0];
				if (wide[PHASE_W]) begin
					shifted = noise_lfsr[0];
					noise_lfsr = noise_lfsr >> 1;
					if (shifted)
						noise_lfsr = noise_lfsr ^ LFSR_TAPS;
				end
				total += noise_lfsr[0] ? int'(noise_vol) : -int'(noise_vol);
			end
			if (total > MIX_MAX)
				total = MIX_MAX;
			if (total < MIX_MIN)
				total = MIX_MIN;
			pending_mix.push_back(MIX_W'(total));
		end
	endtask

	task automatic send_req(input logic [REQ_TYPE_W-1:0] rt, input logic [CHANNEL_W-1:0] ch,
			input logic [VALUE_W-1:0] val);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				req_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_if.valid    <= 1'b1;
		req_if.req_type <= rt;
		req_if.channel  <= ch;
		req_if.value    <= val;
		do @(posedge clk); while (!req_if.ready);
		advance_mixer(rt, ch, val);
	endtask

	task automatic req_idle();
		req_if.valid <= 1'b0;
		burst_left = 0;
	endtask

	task automatic test_reset_silence();
		repeat (3) send_req(REQ_TICK, 2'd0, 16'h0000);
	endtask

	task automatic test_volume_clamp();
		send_req(REQ_FREQ, 2'd0, 16'd1000);
		send_req(REQ_VOLUME, 2'd0, 16'd16);
		send_req(REQ_TICK, 2'd0, 16'hFFFF);
		send_req(REQ_VOLUME, 2'd1, 16'hFF0A);
		send_req(REQ_FREQ, 2'd1, 16'd24000);
		send_req(REQ_TICK, 2'd3, 16'h0000);
		send_req(REQ_VOLUME, 2'd0, 16'd0);
		send_req(REQ_TICK, 2'd1, 16'h5555);
	endtask

	task automatic test_freq_extremes();
		send_req(REQ_FREQ, 2'd2, 16'hFFFF);
		send_req(REQ_VOLUME, 2'd2, 16'd255);
		send_req(REQ_TICK, 2'd0, 16'h0000);
		send_req(REQ_FREQ, 2'd2, 16'd1);
		send_req(REQ_TICK, 2'd0, 16'h0000);
		send_req(REQ_FREQ, 2'd2, 16'd0);
		send_req(REQ_TICK, 2'd0, 16'h0000);
	endtask

	task automatic test_noise_channel();
		send_req(REQ_FREQ, NOISE_CH, 16'd24000);
		send_req(REQ_VOLUME, NOISE_CH, 16'h008F);
		repeat (3) send_req(REQ_TICK, 2'd0, 16'h0000);
		send_req(REQ_VOLUME, NOISE_CH, 16'h0080);
		send_req(REQ_TICK, 2'd0, 16'h0000);
	endtask

	task automatic test_reserved_request();
		send_req(REQ_RESERVED, 2'd0, 16'hFFFF);
		send_req(REQ_RESERVED, NOISE_CH, 16'h0000);
		send_req(REQ_TICK, 2'd2, 16'hAAAA);
	endtask

	task automatic test_random_traffic(input int count);
		int pick;
		logic [REQ_TYPE_W-1:0] rt;
		logic [VALUE_W-1:0] val;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			val  = VALUE_W'($urandom_range(0, 65535));
			if (pick < 60) begin
				rt = REQ_TICK;
			end else if (pick < 77) begin
				rt = REQ_VOLUME;
				case ($urandom_range(0, 2))
					0: val = VALUE_W'($urandom_range(0, MAX_VOLUME));
					1: val = VALUE_W'($urandom_range(0, 255));
					default: ;
				endcase
			end else if (pick < 95) begin
				rt = REQ_FREQ;
				case ($urandom_range(0, 3))
					0: val = VALUE_W'($urandom_range(0, 200));
					1: val = VALUE_W'($urandom_range(0, 3) * 12000);
					default: ;
				endcase
			end else begin
				rt = REQ_RESERVED;
			end
			send_req(rt, CHANNEL_W'($urandom_range(0, 3)), val);
		end
	endtask

	task automatic test_backpressure();
		no_gaps = 1'b1;
		burst_left = 0;
		send_req(REQ_FREQ, NOISE_CH, 16'd30011);
		send_req(REQ_VOLUME, NOISE_CH, 16'h00FF);
		hold_off_req = 1'b1;
		repeat (40) send_req(REQ_TICK, CHANNEL_W'($urandom_range(0, 3)),
			VALUE_W'($urandom_range(0, 65535)));
		no_gaps = 1'b0;
	endtask

	initial begin
		int hold_left;
		int seg_left;
		int mode;
		int cyc;
		hold_left = 0;
		seg_left  = 0;
		mode      = 0;
		cyc       = 0;
		mix_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (hold_left > 0) begin
				hold_left--;
				mix_if.ready <= 1'b0;
			end else if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left = HOLD_CYCLES;
				mix_if.ready <= 1'b0;
			end else begin
				if (seg_left == 0) begin
					seg_left = $urandom_range(20, 100);
					mode = $urandom_range(0, 2);
				end
				seg_left--;
				case (mode)
					0: mix_if.ready <= 1'b1;
					1: mix_if.ready <= 1'($urandom_range(0, 1));
					default: mix_if.ready <= (cyc % 4 != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		logic signed [MIX_W-1:0] want;
		if (mix_if.valid && mix_if.ready) begin
			if (pending_mix.size() == 0) begin
				$display("%0t: unexpected mix_sum transfer: expected none, got %0d",
					$time, mix_if.mix_sum);
				errors++;
			end else begin
				want = pending_mix.pop_front();
				if (mix_if.mix_sum !== want) begin
					$display("%0t: mix_sum mismatch: expected %0d, got %0d",
						$time, want, mix_if.mix_sum);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (mix_if.valid && mix_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: watchdog expired with %0d results outstanding", $time,
				pending_mix.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		errors       = 0;
		burst_left   = 0;
		no_gaps      = 1'b0;
		hold_off_req = 1'b0;
		idle_cycles  = 0;
		arst_n       = 1'b0;
		req_if.valid    = 1'b0;
		req_if.req_type = REQ_TICK;
		req_if.channel  = '0;
		req_if.value    = '0;
		clear_mixer_state();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_silence();
		test_volume_clamp();
		test_freq_extremes();
		test_noise_channel();
		test_reserved_request();
		test_random_traffic(380);
		test_backpressure();
		test_random_traffic(60);
		req_idle();

		while (pending_mix.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_mix.size() != 0) begin
			$display("%0t: %0d mix_sum results never arrived", $time, pending_mix.size());
			errors++;
		end
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
`default_nettype wire
